[design/text_console_writer_top_defines.svh]
// Assertion macros shared by the text console writer design files.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/tcw_pkg.sv]
// Shared constants, types and command/status structs of the text console writer.
package tcw_pkg;

   // Screen memory geometry.
   localparam int MAX_COLS   = 128;
   localparam int MAX_ROWS   = 64;
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;

   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int WID_W  = $clog2(MAX_COLS + 1);
   localparam int HGT_W  = $clog2(MAX_ROWS + 1);
   localparam int PROD_W = ROW_W + WID_W + 1;

   // Field widths of the request and response.
   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = CHAR_W + ATTR_W;
   localparam int POS_W    = 13;

   // Configuration registers.
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 8;
   localparam int SCREEN_WIDTH_W   = 8;
   localparam int SCREEN_HEIGHT_W  = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 1'b1;
   localparam logic [SCREEN_WIDTH_W-1:0]  WIDTH_RESET  = 8'd80;
   localparam logic [SCREEN_HEIGHT_W-1:0] HEIGHT_RESET = 7'd25;

   // Character constants.
   localparam logic [ATTR_W-1:0] TEXT_ATTR = 8'h07;
   localparam logic [CHAR_W-1:0] NEWLINE   = 8'h0a;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_SET   = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic exec;
      logic wipe;
      logic scroll_step;
      logic respond;
   } tcw_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      action_type action;
      logic       need_scroll;
      logic       wipe_last;
      logic       scroll_last;
   } tcw_stat_type;

endpackage

[design/tcw_ctrl.sv]
// Controller state machine of the text console writer.
module tcw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output tcw_pkg::tcw_cmd_type  cmd,
   input  tcw_pkg::tcw_stat_type stat
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL,
      ST_DRAIN,
      ST_WIPE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.wipe = 1'b1;
            if (stat.wipe_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            case (stat.action)
               ACT_WRITE: begin
                  if (stat.need_scroll) begin
                     state_in = ST_SCROLL;
                  end else begin
                     cmd.respond = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end
               ACT_CLEAR: state_in = ST_WIPE;
               ACT_READ:  state_in = ST_READ;
               default: begin
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
               end
            endcase
         end
         ST_READ: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (stat.scroll_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_WIPE: begin
            cmd.wipe = 1'b1;
            if (stat.wipe_last) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

[design/tcw_dpath.sv]
// Datapath of the text console writer: cursor, screen memory and response registers.
module tcw_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  tcw_pkg::tcw_cmd_type               cmd,
   output tcw_pkg::tcw_stat_type              stat,
   input  logic                               csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [tcw_pkg::ACTION_W-1:0]       req_action,
   input  logic [tcw_pkg::CHAR_W-1:0]         req_char_code,
   input  logic                               req_end_of_text,
   input  logic [tcw_pkg::ROW_W-1:0]          req_target_row,
   input  logic [tcw_pkg::COL_W-1:0]          req_target_col,
   output logic                               rsp_strobe,
   output logic [tcw_pkg::ROW_W-1:0]          rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]          rsp_cursor_col,
   output logic [tcw_pkg::POS_W-1:0]          rsp_cursor_pos,
   output logic                               rsp_cursor_update,
   output logic                               rsp_scrolled,
   output logic [tcw_pkg::CHAR_W-1:0]         rsp_read_char,
   output logic [tcw_pkg::ATTR_W-1:0]         rsp_read_attr
);
   import tcw_pkg::*;

   logic [SCREEN_WIDTH_W-1:0]  width_ff;
   logic [SCREEN_HEIGHT_W-1:0] height_ff;
   logic [WID_W-1:0]           w_eff;
   logic [HGT_W-1:0]           h_eff;
   logic [HGT_W-1:0]           hm1;
   logic [ROW_W-1:0]           hm1_row;
   logic [COL_W-1:0]           wm1_col;

   action_type                 action_ff;
   logic [CHAR_W-1:0]          char_ff;
   logic                       eot_ff;
   logic [ROW_W-1:0]           trow_ff;
   logic [COL_W-1:0]           tcol_ff;

   logic [ROW_W-1:0]           row_ff;
   logic [ROW_W-1:0]           row_in;
   logic [COL_W-1:0]           col_ff;
   logic [COL_W-1:0]           col_in;
   logic [ADDR_W-1:0]          pos_ff;
   logic [ADDR_W-1:0]          pos_in;
   logic                       upd_ff;
   logic                       upd_in;
   logic                       scr_ff;
   logic                       scr_in;
   logic                       rd_ok_ff;
   logic                       rd_ok_in;
   logic [ADDR_W-1:0]          keep_ff;
   logic [ADDR_W-1:0]          keep_in;
   logic [ADDR_W-1:0]          cnt_ff;
   logic [ADDR_W-1:0]          cnt_in;

   logic                       pwr_en_ff;
   logic [ADDR_W-1:0]          paddr_ff;
   logic                       pzero_ff;

   logic                       rsp_strobe_ff;
   logic [CHAR_W-1:0]          rchar_ff;
   logic [ATTR_W-1:0]          rattr_ff;

   logic [ROW_W-1:0]           rc;
   logic [COL_W-1:0]           cc;
   logic [WID_W-1:0]           col_t;
   logic [HGT_W-1:0]           row_t;
   logic                       wr_char;
   logic [ROW_W-1:0]           addr_row;
   logic [COL_W-1:0]           addr_col;
   logic [PROD_W-1:0]          cell_prod;
   logic [PROD_W-1:0]          pos_prod;
   logic [PROD_W-1:0]          keep_prod;
   logic [ADDR_W-1:0]          cell_addr;
   logic [ADDR_W-1:0]          last_addr;
   logic                       rd_load;

   logic [CELL_W-1:0]          mem [CELL_COUNT];
   logic [CELL_W-1:0]          rdata_ff;
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_waddr;
   logic [CELL_W-1:0]          mem_wdata;
   logic [ADDR_W-1:0]          mem_raddr;

   // Effective screen size, saturated into 1..MAX.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WID_W'(1);
      end else if (int'(width_ff) > MAX_COLS) begin
         w_eff = WID_W'(MAX_COLS);
      end else begin
         w_eff = WID_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HGT_W'(1);
      end else if (int'(height_ff) > MAX_ROWS) begin
         h_eff = HGT_W'(MAX_ROWS);
      end else begin
         h_eff = HGT_W'(height_ff);
      end
   end

   assign hm1     = h_eff - HGT_W'(1);
   assign hm1_row = ROW_W'(hm1);
   assign wm1_col = COL_W'(w_eff - WID_W'(1));

   // The cursor may lie outside the screen after a size change.
   assign rc    = (HGT_W'(row_ff) > hm1) ? hm1_row : row_ff;
   assign cc    = (col_ff > wm1_col) ? wm1_col : col_ff;
   assign col_t = WID_W'(cc) + WID_W'(1);

   // Next cursor and flags for the item being executed.
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      upd_in   = 1'b0;
      scr_in   = 1'b0;
      rd_ok_in = 1'b0;
      wr_char  = 1'b0;
      row_t    = HGT_W'(rc);
      case (action_ff)
         ACT_WRITE: begin
            if (char_ff == NEWLINE) begin
               col_in = '0;
               row_t  = HGT_W'(rc) + HGT_W'(1);
            end else begin
               wr_char = 1'b1;
               if (col_t == w_eff) begin
                  col_in = '0;
                  row_t  = HGT_W'(rc) + HGT_W'(1);
               end else begin
                  col_in = COL_W'(col_t);
               end
            end
            if (row_t == h_eff) begin
               scr_in = 1'b1;
               row_in = hm1_row;
            end else begin
               row_in = ROW_W'(row_t);
            end
            upd_in = eot_ff;
         end
         ACT_CLEAR: begin
            row_in = '0;
            col_in = '0;
         end
         ACT_SET: begin
            row_in = (HGT_W'(trow_ff) < h_eff) ? trow_ff : hm1_row;
            col_in = (WID_W'(tcol_ff) < w_eff) ? tcol_ff : wm1_col;
            upd_in = 1'b1;
         end
         ACT_READ: begin
            rd_ok_in = (HGT_W'(trow_ff) < h_eff) && (WID_W'(tcol_ff) < w_eff);
         end
         default: begin
            row_in = row_ff;
         end
      endcase
   end

   // One multiplier forms the cell address of a write or a read; others form the cursor position and scroll bounds.
   assign addr_row  = (action_ff == ACT_READ) ? trow_ff : rc;
   assign addr_col  = (action_ff == ACT_READ) ? tcol_ff : cc;
   assign cell_prod = PROD_W'(addr_row) * PROD_W'(w_eff);
   assign cell_addr = ADDR_W'(cell_prod + PROD_W'(addr_col));
   assign pos_prod  = PROD_W'(row_in) * PROD_W'(w_eff);
   assign pos_in    = ADDR_W'(pos_prod + PROD_W'(col_in));
   assign keep_prod = PROD_W'(hm1) * PROD_W'(w_eff);
   assign keep_in   = ADDR_W'(keep_prod);
   assign last_addr = ADDR_W'(PROD_W'(keep_ff) + PROD_W'(w_eff) - PROD_W'(1));
   assign cnt_in    = cnt_ff + ADDR_W'(1);

   assign stat.action      = action_ff;
   assign stat.need_scroll = scr_in;
   assign stat.wipe_last   = (cnt_ff == ADDR_W'(CELL_COUNT - 1));
   assign stat.scroll_last = (cnt_ff == last_addr);

   // Memory port selection.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = '0;
      if (cmd.wipe) begin
         mem_we = 1'b1;
      end else if (pwr_en_ff) begin
         mem_we    = 1'b1;
         mem_waddr = paddr_ff;
         mem_wdata = pzero_ff ? '0 : rdata_ff;
      end else if (cmd.exec && wr_char) begin
         mem_we    = 1'b1;
         mem_waddr = cell_addr;
         mem_wdata = {TEXT_ATTR, char_ff};
      end
   end

   assign mem_raddr = cmd.scroll_step ?
                      ADDR_W'(PROD_W'(cnt_ff) + PROD_W'(w_eff)) : cell_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign rd_load = (action_ff == ACT_READ) && rd_ok_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
         cnt_ff        <= '0;
         pwr_en_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  width_ff  <= SCREEN_WIDTH_W'(csr_wdata);
               CSR_SCREEN_HEIGHT: height_ff <= SCREEN_HEIGHT_W'(csr_wdata);
               default:           width_ff  <= width_ff;
            endcase
         end
         if (cmd.exec) begin
            row_ff <= row_in;
            col_ff <= col_in;
            cnt_ff <= '0;
         end else if (cmd.wipe || cmd.scroll_step) begin
            cnt_ff <= cnt_in;
         end
         pwr_en_ff     <= cmd.scroll_step;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= action_type'(req_action);
         char_ff   <= req_char_code;
         eot_ff    <= req_end_of_text;
         trow_ff   <= req_target_row;
         tcol_ff   <= req_target_col;
      end
      if (cmd.exec) begin
         pos_ff   <= pos_in;
         upd_ff   <= upd_in;
         scr_ff   <= scr_in;
         rd_ok_ff <= rd_ok_in;
         keep_ff  <= keep_in;
      end
      paddr_ff <= cnt_ff;
      pzero_ff <= (cnt_ff >= keep_ff);
      if (cmd.respond) begin
         rchar_ff <= rd_load ? rdata_ff[CHAR_W-1:0] : '0;
         rattr_ff <= rd_load ? rdata_ff[CELL_W-1:CHAR_W] : '0;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_cursor_row    = row_ff;
   assign rsp_cursor_col    = col_ff;
   assign rsp_cursor_pos    = POS_W'(pos_ff);
   assign rsp_cursor_update = upd_ff;
   assign rsp_scrolled      = scr_ff;
   assign rsp_read_char     = rchar_ff;
   assign rsp_read_attr     = rattr_ff;

endmodule

[design/text_console_writer_top.sv]
// Top level of the text console writer: controller, datapath and checks.
//
// A text console over an 8192-cell screen memory (16-bit cells, character in the low
// byte, attribute in the high byte). A request is taken when start is high and busy is
// low; every request yields exactly one response, shown for one cycle with rsp_strobe
// high, and the receiver cannot stall it. Writing a character without a scroll or setting
// the cursor is answered from the execute state, and reading a cell passes through a
// further read state, because the read of the screen memory is registered. A character
// write that runs past the last row scrolls the screen by copying cell by cell, each
// cell read from the row below through the registered read port and written back a
// row higher, the last row with zeros. Clearing the screen writes every memory cell
// once. After reset the block runs the same clearing pass over the memory, and busy
// stays high until it ends, so no request can be taken before then. The screen size
// registers may be written at any time the block is idle; a width of 0 acts as 1 and
// sizes beyond the memory are limited to 128 columns and 64 rows.
module text_console_writer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tcw_pkg::ACTION_W-1:0]   req_action,
   input  logic [tcw_pkg::CHAR_W-1:0]     req_char_code,
   input  logic                           req_end_of_text,
   input  logic [tcw_pkg::ROW_W-1:0]      req_target_row,
   input  logic [tcw_pkg::COL_W-1:0]      req_target_col,
   output logic                           rsp_strobe,
   output logic [tcw_pkg::ROW_W-1:0]      rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]      rsp_cursor_col,
   output logic [tcw_pkg::POS_W-1:0]      rsp_cursor_pos,
   output logic                           rsp_cursor_update,
   output logic                           rsp_scrolled,
   output logic [tcw_pkg::CHAR_W-1:0]     rsp_read_char,
   output logic [tcw_pkg::ATTR_W-1:0]     rsp_read_attr,
   input  logic                           csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tcw_pkg::*;

`include "text_console_writer_top_defines.svh"

   // Commands flow from the controller to the datapath, status flows back.
   tcw_cmd_type  cmd;
   tcw_stat_type stat;

   // The controller sequences each request: execute, then scroll, clear or read as needed.
   tcw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // The datapath holds the cursor, the screen memory and the response registers.
   tcw_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_action        (req_action),
      .req_char_code     (req_char_code),
      .req_end_of_text   (req_end_of_text),
      .req_target_row    (req_target_row),
      .req_target_col    (req_target_col),
      .rsp_strobe        (rsp_strobe),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_pos    (rsp_cursor_pos),
      .rsp_cursor_update (rsp_cursor_update),
      .rsp_scrolled      (rsp_scrolled),
      .rsp_read_char     (rsp_read_char),
      .rsp_read_attr     (rsp_read_attr)
   );

   // Every request returns to the idle state before the next, so responses never come back to back.
   `TCW_ASSERT_NEXT(a_strobe_spaced, clock, reset, rsp_strobe, !rsp_strobe, "back-to-back responses")

   // An accepted request makes the block busy in the following cycle.
   `TCW_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy, "busy did not rise after a request")

   // A scroll only happens when the cursor wraps to the start of a new row.
   `TCW_ASSERT_NOW(a_scroll_col_zero, clock, reset, rsp_strobe && rsp_scrolled, rsp_cursor_col == '0, "scrolled with nonzero column")

   // Cell data only comes from a read, which neither scrolls nor updates the cursor.
   `TCW_ASSERT_NOW(a_read_clean, clock, reset, rsp_strobe && (rsp_read_char != '0 || rsp_read_attr != '0), !rsp_cursor_update && !rsp_scrolled, "read data with write flags")

endmodule
